// ===== design/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg
// Types, constants and clamp helpers shared by the servo slew ramp block.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int JOINT_COUNT = 6;
  localparam int PW          = 12;   // pulse value width
  localparam int JW          = 3;    // joint index width
  localparam int AW          = 5;    // config byte address width
  localparam int DW          = 32;   // config data width

  localparam logic [PW-1:0] INIT_PULSE = PW'(1500);
  localparam logic [PW-1:0] FAST_STEP  = PW'(2);

  typedef enum logic [1:0] {
    OP_SET_TARGET = 2'd0,
    OP_TICK       = 2'd1,
    OP_SET_POS    = 2'd2,
    OP_NOP        = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_FULL_MIN  = 3'd0,
    REG_FULL_MAX  = 3'd1,
    REG_SLOW_LOW  = 3'd2,
    REG_SLOW_HIGH = 3'd3,
    REG_WIDE_LOW  = 3'd4,
    REG_WIDE_HIGH = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLASS_FULL = 2'd0,
    CLASS_SLOW = 2'd1,
    CLASS_WIDE = 2'd2
  } limit_class_t;

  typedef struct packed {
    logic [PW-1:0] full_min;
    logic [PW-1:0] full_max;
    logic [PW-1:0] slow_zone_low;
    logic [PW-1:0] slow_zone_high;
    logic [PW-1:0] wide_limit_low;
    logic [PW-1:0] wide_limit_high;
  } limits_t;

  // base: full; elbow, wrist: wide; shoulder, thumb, finger: slow zone
  function automatic limit_class_t joint_class(input logic [JW-1:0] j);
    limit_class_t c;
    case (j)
      3'd0:         c = CLASS_FULL;
      3'd2, 3'd3:   c = CLASS_WIDE;
      default:      c = CLASS_SLOW;
    endcase
    return c;
  endfunction

  // Upper limit first, then lower: lower limit wins if the pair is crossed
  function automatic logic [PW-1:0] clamp_to(input logic [PW-1:0] v,
                                             input logic [PW-1:0] lo,
                                             input logic [PW-1:0] hi);
    logic [PW-1:0] r;
    r = (v > hi) ? hi : v;
    r = (r < lo) ? lo : r;
    return r;
  endfunction

  function automatic logic [PW-1:0] clamp_joint(input limit_class_t c,
                                                input limits_t lim,
                                                input logic [PW-1:0] v);
    logic [PW-1:0] r;
    case (c)
      CLASS_FULL: r = clamp_to(v, lim.full_min, lim.full_max);
      CLASS_SLOW: r = clamp_to(v, lim.slow_zone_low, lim.slow_zone_high);
      default:    r = clamp_to(v, lim.wide_limit_low, lim.wide_limit_high);
    endcase
    return r;
  endfunction

endpackage

// ===== design/msr_in_if.sv =====
// ----------------------------------------------------------------------------
// msr_in_if
// Command channel: opcode, joint index and requested pulse value.
// ----------------------------------------------------------------------------
interface msr_in_if
  import msr_pkg::*;
();
  logic          valid;
  logic          ready;
  logic [1:0]    op;
  logic [JW-1:0] joint;
  logic [PW-1:0] value;

  modport source (output valid, output op, output joint, output value, input ready);
  modport sink   (input valid, input op, input joint, input value, output ready);
endinterface

// ===== design/msr_out_if.sv =====
// ----------------------------------------------------------------------------
// msr_out_if
// Result channel: reported joint, its position and target, arrival flags.
// ----------------------------------------------------------------------------
interface msr_out_if
  import msr_pkg::*;
();
  logic          valid;
  logic          ready;
  logic [JW-1:0] joint_out;
  logic [PW-1:0] position;
  logic [PW-1:0] target;
  logic          at_target;
  logic          all_at_target;

  modport source (output valid, output joint_out, output position, output target,
                  output at_target, output all_at_target, input ready);
  modport sink   (input valid, input joint_out, input position, input target,
                  input at_target, input all_at_target, output ready);
endinterface

// ===== design/msr_joint_step.sv =====
// ----------------------------------------------------------------------------
// msr_joint_step
// One slew step of a single joint toward its target, with limit clamping.
// ----------------------------------------------------------------------------
module msr_joint_step
  import msr_pkg::*;
(
  input  limits_t       lim,
  input  limit_class_t  cls,
  input  logic [PW-1:0] cur,
  input  logic [PW-1:0] tgt,
  output logic [PW-1:0] pos_nxt
);

  logic [PW-1:0] goal;
  logic          fast;
  logic [PW-1:0] moved;
  logic [PW-1:0] full_clamped;

  always_comb begin
    goal = clamp_to(tgt, lim.full_min, lim.full_max);
    fast = (cur < lim.slow_zone_low) || (cur > lim.slow_zone_high);
    if (cur < goal) begin
      if (fast) moved = ((goal - cur) >= FAST_STEP) ? cur + FAST_STEP : goal;
      else      moved = cur + PW'(1);
    end else if (cur > goal) begin
      if (fast) moved = ((cur - goal) >= FAST_STEP) ? cur - FAST_STEP : goal;
      else      moved = cur - PW'(1);
    end else begin
      moved = cur;
    end
    // upper limit takes precedence here, unlike the per-joint clamp
    if (moved > lim.full_max)      full_clamped = lim.full_max;
    else if (moved < lim.full_min) full_clamped = lim.full_min;
    else                           full_clamped = moved;
    pos_nxt = clamp_joint(cls, lim, full_clamped);
  end

endmodule

// ===== design/multi_joint_servo_slew_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// multi_joint_servo_slew_ramp_unit
// Six-joint servo slew limiter with APB limit registers.
// ----------------------------------------------------------------------------
// Each accepted command gives exactly one result beat via the input and
// output registers. Commands are taken one per cycle while the output is
// not stalled: an input register feeds a single pass in which all six
// joints step in parallel on a tick and the position/target registers
// update, and an output register holds the result so the next command is
// taken while a result waits. The joint state registers bound the rate.
// Limit registers must only be written while no command is in flight.
module multi_joint_servo_slew_ramp_unit
  import msr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  msr_in_if.sink         in_ch,
  msr_out_if.source      out_ch,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [AW-1:0]  paddr,
  input  logic [DW-1:0]  pwdata,
  output logic [DW-1:0]  prdata,
  output logic           pready
);

  // ---------------- configuration ----------------
  limits_t       lim_r;
  logic          cfg_wr;
  reg_idx_t      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.full_min        <= PW'(0);
      lim_r.full_max        <= PW'(3000);
      lim_r.slow_zone_low   <= PW'(500);
      lim_r.slow_zone_high  <= PW'(2500);
      lim_r.wide_limit_low  <= PW'(250);
      lim_r.wide_limit_high <= PW'(2750);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FULL_MIN:  lim_r.full_min        <= pwdata[PW-1:0];
        REG_FULL_MAX:  lim_r.full_max        <= pwdata[PW-1:0];
        REG_SLOW_LOW:  lim_r.slow_zone_low   <= pwdata[PW-1:0];
        REG_SLOW_HIGH: lim_r.slow_zone_high  <= pwdata[PW-1:0];
        REG_WIDE_LOW:  lim_r.wide_limit_low  <= pwdata[PW-1:0];
        REG_WIDE_HIGH: lim_r.wide_limit_high <= pwdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FULL_MIN:  prdata = DW'(lim_r.full_min);
      REG_FULL_MAX:  prdata = DW'(lim_r.full_max);
      REG_SLOW_LOW:  prdata = DW'(lim_r.slow_zone_low);
      REG_SLOW_HIGH: prdata = DW'(lim_r.slow_zone_high);
      REG_WIDE_LOW:  prdata = DW'(lim_r.wide_limit_low);
      REG_WIDE_HIGH: prdata = DW'(lim_r.wide_limit_high);
      default:       prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic          s1_valid_r;
  op_t           s1_op_r;
  logic [JW-1:0] s1_joint_r;
  logic [PW-1:0] s1_value_r;
  logic          out_valid_r;
  logic          adv;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r    <= op_t'(in_ch.op);
      s1_joint_r <= in_ch.joint;
      s1_value_r <= in_ch.value;
    end
  end

  // ---------------- joint state update ----------------
  logic [PW-1:0] pos_r   [JOINT_COUNT];
  logic [PW-1:0] tgt_r   [JOINT_COUNT];
  logic [PW-1:0] pos_nxt [JOINT_COUNT];
  logic [PW-1:0] tgt_nxt [JOINT_COUNT];
  logic [PW-1:0] step_pos[JOINT_COUNT];
  logic          do_upd;

  assign do_upd = s1_valid_r && adv;

  for (genvar k = 0; k < JOINT_COUNT; k++) begin : g_joint
    logic [PW-1:0] set_val;
    logic          hit;

    msr_joint_step u_step (
      .lim     (lim_r),
      .cls     (joint_class(JW'(k))),
      .cur     (pos_r[k]),
      .tgt     (tgt_r[k]),
      .pos_nxt (step_pos[k])
    );

    assign set_val = clamp_joint(joint_class(JW'(k)), lim_r, s1_value_r);
    assign hit     = (s1_joint_r == JW'(k));

    always_comb begin
      pos_nxt[k] = pos_r[k];
      tgt_nxt[k] = tgt_r[k];
      case (s1_op_r)
        OP_TICK:       pos_nxt[k] = step_pos[k];
        OP_SET_TARGET: if (hit) tgt_nxt[k] = set_val;
        OP_SET_POS:    if (hit) pos_nxt[k] = set_val;
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r[k] <= INIT_PULSE;
        tgt_r[k] <= INIT_PULSE;
      end else if (do_upd) begin
        pos_r[k] <= pos_nxt[k];
        tgt_r[k] <= tgt_nxt[k];
      end
    end
  end

  // ---------------- result ----------------
  logic [PW-1:0] rep_pos;
  logic [PW-1:0] rep_tgt;
  logic          rep_at;
  logic          all_at;

  always_comb begin
    rep_pos = '0;
    rep_tgt = '0;
    all_at  = 1'b1;
    for (int k = 0; k < JOINT_COUNT; k++) begin
      if (s1_joint_r == JW'(k)) begin
        rep_pos = pos_nxt[k];
        rep_tgt = tgt_nxt[k];
      end
      if (pos_nxt[k] != tgt_nxt[k]) all_at = 1'b0;
    end
    // out-of-range joint reports zeros, and zero equals zero is not "at target"
    rep_at = (s1_joint_r < JW'(JOINT_COUNT)) && (rep_pos == rep_tgt);
  end

  logic [JW-1:0] out_joint_r;
  logic [PW-1:0] out_pos_r;
  logic [PW-1:0] out_tgt_r;
  logic          out_at_r;
  logic          out_all_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_upd) begin
      out_joint_r <= s1_joint_r;
      out_pos_r   <= rep_pos;
      out_tgt_r   <= rep_tgt;
      out_at_r    <= rep_at;
      out_all_r   <= all_at;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.joint_out     = out_joint_r;
  assign out_ch.position      = out_pos_r;
  assign out_ch.target        = out_tgt_r;
  assign out_ch.at_target     = out_at_r;
  assign out_ch.all_at_target = out_all_r;

  // ---------------- assertions ----------------
  a_bad_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_joint_r >= JW'(JOINT_COUNT)) |->
      (out_pos_r == '0) && (out_tgt_r == '0) && !out_at_r)
    else $error("out-of-range joint reported non-zero values");

  a_at_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_at_r |-> (out_pos_r == out_tgt_r))
    else $error("at_target set with position different from target");

  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_joint_r) && $stable(s1_value_r))
    else $error("staged command lost while output stalled");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !do_upd |=> (pos_r[0] == $past(pos_r[0])) && (tgt_r[0] == $past(tgt_r[0])))
    else $error("joint state changed without a command");

endmodule
